// ===== hdl/acds_pkg.sv =====
// Shared types and constants for the axis calibration and deadzone core.
// No dependencies; used by acds_cfg_regs and the axis core (acds_div_pipe does not use it).
package acds_pkg;

  localparam int FracBitsDefault = 16;

  localparam int SampleW = 17;
  localparam int DzW     = 16;
  localparam int OutW    = 8;
  localparam int PaddrW  = 5;
  localparam int PdataW  = 32;

  // Divisor used when no calibration is loaded.
  localparam logic [SampleW-1:0] FullScaleDiv = 17'd32767;

  typedef enum logic [2:0] {
    RegCalValid  = 3'd0,
    RegCalMin    = 3'd1,
    RegCalMax    = 3'd2,
    RegCalCenter = 3'd3,
    RegDeadzone  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic                      cal_valid;
    logic signed [SampleW-1:0] cal_min;
    logic signed [SampleW-1:0] cal_max;
    logic signed [SampleW-1:0] cal_center;
    logic        [DzW-1:0]     deadzone;
  } cfg_t;

endpackage

// ===== hdl/acds_cfg_regs.sv =====
// APB register file holding calibration and deadzone settings.
// Depends on acds_pkg for the register map and the cfg_t bundle.
module acds_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [acds_pkg::PaddrW-1:0]  paddr,
  input  logic [acds_pkg::PdataW-1:0]  pwdata,
  output logic [acds_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output acds_pkg::cfg_t               cfg_o
);

  acds_pkg::cfg_t     cfg_q, cfg_d;
  acds_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = acds_pkg::reg_idx_e'(paddr[acds_pkg::PaddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        acds_pkg::RegCalValid:  cfg_d.cal_valid  = pwdata[0];
        acds_pkg::RegCalMin:    cfg_d.cal_min    = pwdata[acds_pkg::SampleW-1:0];
        acds_pkg::RegCalMax:    cfg_d.cal_max    = pwdata[acds_pkg::SampleW-1:0];
        acds_pkg::RegCalCenter: cfg_d.cal_center = pwdata[acds_pkg::SampleW-1:0];
        acds_pkg::RegDeadzone:  cfg_d.deadzone   = pwdata[acds_pkg::DzW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      acds_pkg::RegCalValid:  prdata = {31'd0, cfg_q.cal_valid};
      acds_pkg::RegCalMin:    prdata = {{15{cfg_q.cal_min[16]}}, cfg_q.cal_min};
      acds_pkg::RegCalMax:    prdata = {{15{cfg_q.cal_max[16]}}, cfg_q.cal_max};
      acds_pkg::RegCalCenter: prdata = {{15{cfg_q.cal_center[16]}}, cfg_q.cal_center};
      acds_pkg::RegDeadzone:  prdata = {16'd0, cfg_q.deadzone};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_valid  <= 1'b0;
      cfg_q.cal_min    <= 17'sd0;
      cfg_q.cal_max    <= 17'sd65535;
      cfg_q.cal_center <= 17'sd32768;
      cfg_q.deadzone   <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/acds_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; the caller guarantees the starting remainder is below twice the divisor.
module acds_div_pipe #(
  parameter int DEN_W  = 17,
  parameter int Q_BITS = 17,
  parameter int TAG_W  = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [DEN_W:0]    rem_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output logic [Q_BITS-1:0] quo_o,
  output logic [TAG_W-1:0]  tag_o
);

  localparam int RemW = DEN_W + 1;

  logic [Q_BITS-1:0] vld_q;
  logic [RemW-1:0]   rem_q [Q_BITS];
  logic [DEN_W-1:0]  den_q [Q_BITS];
  logic [Q_BITS-1:0] quo_q [Q_BITS];
  logic [TAG_W-1:0]  tag_q [Q_BITS];

  for (genvar g = 0; g < Q_BITS; g++) begin : g_stage
    logic              vld_in;
    logic [RemW-1:0]   rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [Q_BITS-1:0] quo_in;
    logic [TAG_W-1:0]  tag_in;
    logic              ge;
    logic [RemW-1:0]   diff;

    if (g == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[g-1];
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
      assign tag_in = tag_q[g-1];
    end

    // The remainder stays below the divisor after the subtract, so doubling it fits.
    assign ge   = rem_in >= {1'b0, den_in};
    assign diff = ge ? (rem_in - {1'b0, den_in}) : rem_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[g] <= {diff[RemW-2:0], 1'b0};
      den_q[g] <= den_in;
      quo_q[g] <= {quo_in[Q_BITS-2:0], ge};
      tag_q[g] <= tag_in;
    end
  end

  assign valid_o = vld_q[Q_BITS-1];
  assign quo_o   = quo_q[Q_BITS-1];
  assign tag_o   = tag_q[Q_BITS-1];

endmodule

// ===== hdl/axis_calibrate_deadzone_s8_core.sv =====
// Axis conditioning core: a raw sample is normalized against the calibration (or full
// scale), passed through the scaled deadzone and mapped to -127..127. A request is
// taken on any cycle with start high; busy never rises, so one request per cycle is
// sustained. Each result appears on axis_value_o for one cycle with done_o high, in
// request order. Between request and result lie the input and saturation registers,
// the normalization divider, the rescale setup register, the rescale divider and the
// output register. Results cannot be held off; the receiver must take them when shown.
module axis_calibrate_deadzone_s8_core #(
  parameter int FRAC_BITS = acds_pkg::FracBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [acds_pkg::SampleW-1:0] raw_sample_i,
  output logic                               done_o,
  output logic signed [acds_pkg::OutW-1:0]    axis_value_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [acds_pkg::PaddrW-1:0]         paddr,
  input  logic [acds_pkg::PdataW-1:0]         pwdata,
  output logic [acds_pkg::PdataW-1:0]         prdata,
  output logic                               pready
);

  localparam int F     = FRAC_BITS;
  localparam int SW    = acds_pkg::SampleW;
  localparam int NumW  = SW + 1;
  localparam int MagW  = F + 1;
  localparam int ProdW = F + 8;

  acds_pkg::cfg_t cfg;

  acds_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy = 1'b0;

  // Stage A: offset from center, span selection and magnitude.
  logic signed [SW-1:0]   cen, cmin, cmax;
  logic signed [NumW-1:0] v_x, c_x, span, d;
  logic                   above;
  logic [NumW-1:0]        abs_d, abs_v;

  assign cen   = cfg.cal_center;
  assign cmin  = cfg.cal_min;
  assign cmax  = cfg.cal_max;
  assign v_x   = {raw_sample_i[SW-1], raw_sample_i};
  assign c_x   = {cen[SW-1], cen};
  assign above = raw_sample_i >= cen;
  assign span  = above ? ({cmax[SW-1], cmax} - c_x) : (c_x - {cmin[SW-1], cmin});
  assign d     = v_x - c_x;
  assign abs_d = d[NumW-1] ? NumW'(-d) : NumW'(d);
  assign abs_v = v_x[NumW-1] ? NumW'(-v_x) : NumW'(v_x);

  logic            a_vld_q;
  logic [NumW-1:0] a_num_q;
  logic [SW-1:0]   a_den_q;
  logic            a_neg_q, a_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg.cal_valid) begin
      a_num_q  <= abs_d;
      a_den_q  <= span[SW-1:0];
      a_neg_q  <= d[NumW-1];
      a_zero_q <= span[NumW-1] || (span == '0);
    end else begin
      a_num_q  <= abs_v;
      a_den_q  <= acds_pkg::FullScaleDiv;
      a_neg_q  <= v_x[NumW-1];
      a_zero_q <= 1'b0;
    end
  end

  // Stage B: saturation check; a quotient of 2.0 or more is replaced by the ceiling.
  logic            ovf;
  logic            b_vld_q;
  logic [NumW-1:0] b_rem_q;
  logic [SW-1:0]   b_den_q;
  logic [2:0]      b_tag_q;

  assign ovf = a_num_q >= {a_den_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_rem_q <= ovf ? '0 : a_num_q;
    b_den_q <= a_den_q;
    b_tag_q <= {a_neg_q, a_zero_q, ovf};
  end

  logic            n_vld;
  logic [MagW-1:0] n_quo;
  logic [2:0]      n_tag;

  acds_div_pipe #(
    .DEN_W  (SW),
    .Q_BITS (MagW),
    .TAG_W  (3)
  ) u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_vld_q),
    .rem_i   (b_rem_q),
    .den_i   (b_den_q),
    .tag_i   (b_tag_q),
    .valid_o (n_vld),
    .quo_o   (n_quo),
    .tag_o   (n_tag)
  );

  // Stage C: deadzone compare and setup of the rescale division.
  logic [F+15:0]   dz_wide;
  logic [F-1:0]    dz;
  logic [MagW-1:0] mag, dz_x, one_x, x, den2;
  logic            zero2, sat;

  assign dz_wide = {cfg.deadzone, {F{1'b0}}};
  assign dz      = dz_wide[F+15:16];
  assign dz_x    = {1'b0, dz};
  assign one_x   = {1'b1, {F{1'b0}}};
  assign mag     = n_tag[0] ? {MagW{1'b1}} : n_quo;
  assign zero2   = n_tag[1] || (mag <= dz_x);
  assign sat     = mag[F];
  assign x       = mag - dz_x;
  assign den2    = one_x - dz_x;

  logic            c_vld_q;
  logic [MagW:0]   c_rem_q;
  logic [MagW-1:0] c_den_q;
  logic [2:0]      c_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= n_vld;
    end
  end

  // Below 1.0 the difference is under the divisor, so the first step starts doubled.
  always_ff @(posedge clk_i) begin
    c_rem_q <= (zero2 || sat) ? '0 : {x, 1'b0};
    c_den_q <= den2;
    c_tag_q <= {n_tag[2], zero2, sat};
  end

  logic         r_vld;
  logic [F-1:0] r_quo;
  logic [2:0]   r_tag;

  acds_div_pipe #(
    .DEN_W  (MagW),
    .Q_BITS (F),
    .TAG_W  (3)
  ) u_dz_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .rem_i   (c_rem_q),
    .den_i   (c_den_q),
    .tag_i   (c_tag_q),
    .valid_o (r_vld),
    .quo_o   (r_quo),
    .tag_o   (r_tag)
  );

  // Stage D: scale by 127, truncate and restore the sign; inside the deadzone the output is zero.
  logic [MagW-1:0]  s;
  logic [ProdW-1:0] prod;
  logic [6:0]       r;
  logic [7:0]       r_x;

  assign s    = r_tag[0] ? one_x : {1'b0, r_quo};
  assign prod = {s, 7'd0} - {7'd0, s};
  assign r    = prod[F+6:F];
  assign r_x  = {1'b0, r};

  logic             d_vld_q;
  logic signed [7:0] d_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= r_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_tag[1]) begin
      d_val_q <= '0;
    end else begin
      d_val_q <= r_tag[2] ? 8'(-r_x) : r_x;
    end
  end

  assign done_o       = d_vld_q;
  assign axis_value_o = d_val_q;

endmodule
